[sv/evr_pkg.sv]
// Shared types, default sizes and the sine table generator for the Euler rotator.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package evr_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int COORD_WIDTH_DEF     = 24;
    localparam int ANGLE_WIDTH_DEF     = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Trig values are unsigned Q1.16 magnitudes, at most 1.0 (65536).
    localparam int TRIG_MAG_WIDTH = 17;
    localparam int TRIG_WIDTH     = TRIG_MAG_WIDTH + 1;
    localparam int FRAC_BITS      = 16;
    localparam longint unsigned TRIG_ONE = 64'd65536;

    // Pi in Q30, used for the table series.
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // One quarter-wave table entry: round(65536 * sin(idx * pi/2 / 2^tab_bits)),
    // worked out with a fixed integer Taylor series in Q30. Elaboration only.
    function automatic logic [TRIG_MAG_WIDTH-1:0] sine_entry(input int unsigned idx,
                                                             input int unsigned tab_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned q;
        x    = (longint'(idx) * PI_Q30) >> (tab_bits + 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 9; k++)
        begin
            term = (term * x2) >> 30;
            case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                8:       term = term / 64'd272;
                default: term = term / 64'd342;
            endcase
            if ((k % 2) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        q = (sum + 64'd8192) >> 14;
        if (q > TRIG_ONE)
            q = TRIG_ONE;
        return q[TRIG_MAG_WIDTH-1:0];
    endfunction

    // Applies the quadrant sign to a table magnitude.
    function automatic logic signed [TRIG_WIDTH-1:0] to_trig(input logic [TRIG_MAG_WIDTH-1:0] mag,
                                                             input logic neg);
        logic signed [TRIG_WIDTH-1:0] v;
        v = signed'({1'b0, mag});
        return neg ? -v : v;
    endfunction

endpackage

`default_nettype wire

[sv/evr_if.sv]
// Valid/ready channel interfaces for the Euler rotator: the point word and the result word.
// Depends on evr_pkg for the default widths.
`timescale 1ns / 1ps
`default_nettype none

interface evr_point_if #(
    parameter int COORD_WIDTH = evr_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = evr_pkg::ANGLE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vec_x;
    logic signed [COORD_WIDTH-1:0] vec_y;
    logic signed [COORD_WIDTH-1:0] vec_z;
    logic signed [ANGLE_WIDTH-1:0] roll_angle;
    logic signed [ANGLE_WIDTH-1:0] yaw_angle;
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;

    modport source (
        output valid, vec_x, vec_y, vec_z, roll_angle, yaw_angle, pitch_angle,
        input  ready
    );
    modport sink (
        input  valid, vec_x, vec_y, vec_z, roll_angle, yaw_angle, pitch_angle,
        output ready
    );
endinterface

interface evr_result_if #(
    parameter int COORD_WIDTH = evr_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;

    modport source (
        output valid, out_x, out_y, out_z,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z,
        output ready
    );
endinterface

`default_nettype wire

[sv/evr_sine_rom.sv]
// Quarter-wave sine table with two registered read ports (sine and cosine of one angle).
// Depends on evr_pkg for the entry generator and the magnitude width.
`timescale 1ns / 1ps
`default_nettype none

module evr_sine_rom #(
    parameter int TABLE_BITS = evr_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 en,
    input  wire logic [TABLE_BITS:0]                  addr_a,
    input  wire logic [TABLE_BITS:0]                  addr_b,
    output logic      [evr_pkg::TRIG_MAG_WIDTH-1:0]   data_a,
    output logic      [evr_pkg::TRIG_MAG_WIDTH-1:0]   data_b
);
    import evr_pkg::*;

    localparam int DEPTH = (1 << TABLE_BITS) + 1;

    logic [TRIG_MAG_WIDTH-1:0] rom_mem [DEPTH];
    logic [TRIG_MAG_WIDTH-1:0] data_a_reg;
    logic [TRIG_MAG_WIDTH-1:0] data_b_reg;

    // Table contents are constants fixed at elaboration.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_entry
        assign rom_mem[i] = sine_entry(i, TABLE_BITS);
    end

    // Both ports read in the same cycle; the data holds while the stage is stalled.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a_reg <= rom_mem[addr_a];
            data_b_reg <= rom_mem[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

`default_nettype wire

[sv/euler_vector_rotate_top.sv]
// Euler rotator: rotates a fixed-point 3D point by roll, pitch and yaw in an 8-stage pipeline.
// Depends on evr_pkg, the channel interfaces in evr_if and evr_sine_rom.
//
// Use: a point word (vec_x/y/z in signed Q.8, and roll, yaw and pitch angles in binary
// units where half the angle range is a half turn) enters on the point channel; the
// rotated point leaves on the result channel, with Y and Z swapped and each coordinate
// saturated to the coordinate range. Both channels move a word when valid and ready are
// high at a rising clock edge.
// From acceptance to the result being offered, a word passes the sine table reads, then a
// multiply stage and an add-and-round stage for each of the three plane rotations, then the
// saturating output register.
// Throughput is one word per cycle while the receiver takes results; each stage holds its own
// multipliers and every table has its own sine and cosine read port.
// Each stage moves on when it is empty or the stage after it moves, so a stalled
// receiver holds the result register and the pipeline fills up behind it; empty slots
// are squeezed out, and point.ready falls only when all eight stages hold a word.
// Reset clears the valid bits only; the pipeline is empty and ready after reset.
`timescale 1ns / 1ps
`default_nettype none

module euler_vector_rotate_top #(
    parameter int COORD_WIDTH     = evr_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH     = evr_pkg::ANGLE_WIDTH_DEF,
    parameter int SINE_TABLE_BITS = evr_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    evr_point_if.sink     point,
    evr_result_if.source  result
);
    import evr_pkg::*;

    localparam int NUM_STAGES = 8;
    localparam int CW         = COORD_WIDTH;
    localparam int IW         = COORD_WIDTH + 4;        // unsaturated intermediates
    localparam int TW         = TRIG_WIDTH;
    localparam int PW         = IW + TW;                // one product
    localparam int SW         = PW + 1;                 // sum of two products
    localparam int STB        = SINE_TABLE_BITS;
    localparam int ROM_AW     = SINE_TABLE_BITS + 1;
    localparam int TAB_N      = 1 << SINE_TABLE_BITS;
    localparam int REST_W     = ANGLE_WIDTH - 2;

    // Angle lanes.
    localparam int ANG_ROLL  = 0;
    localparam int ANG_PITCH = 1;
    localparam int ANG_YAW   = 2;
    localparam int NUM_ANG   = 3;

    localparam logic signed [SW-1:0] HALF_LSB = SW'(1 << (FRAC_BITS - 1));
    localparam logic signed [IW-1:0] SAT_HI   = {{(IW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [IW-1:0] SAT_LO   = {{(IW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    // Table index from the angle bits below the quadrant: truncated or zero padded.
    function automatic logic [STB-1:0] quad_index(input logic [REST_W-1:0] rest);
        logic [REST_W+STB-1:0] wide;
        wide = {rest, {STB{1'b0}}};
        return wide[REST_W+STB-1 -: STB];
    endfunction

    // Odd quadrants read the table backwards.
    function automatic logic [ROM_AW-1:0] rom_addr(input logic [1:0] quad,
                                                   input logic [STB-1:0] idx);
        if (quad[0])
            return ROM_AW'(TAB_N) - {1'b0, idx};
        else
            return {1'b0, idx};
    endfunction

    function automatic logic signed [PW-1:0] mul(input logic signed [IW-1:0] a,
                                                 input logic signed [TW-1:0] b);
        return a * b;
    endfunction

    // Round half up to Q.8: add half an LSB, then floor shift.
    function automatic logic signed [IW-1:0] rnd_sum(input logic signed [PW-1:0] a,
                                                     input logic signed [PW-1:0] b);
        logic signed [SW-1:0] t;
        t = SW'(a) + SW'(b) + HALF_LSB;
        return IW'(t >>> FRAC_BITS);
    endfunction

    function automatic logic signed [IW-1:0] rnd_diff(input logic signed [PW-1:0] a,
                                                      input logic signed [PW-1:0] b);
        logic signed [SW-1:0] t;
        t = SW'(a) - SW'(b) + HALF_LSB;
        return IW'(t >>> FRAC_BITS);
    endfunction

    function automatic logic signed [CW-1:0] saturate(input logic signed [IW-1:0] v);
        if (v > SAT_HI)
            return SAT_HI[CW-1:0];
        else if (v < SAT_LO)
            return SAT_LO[CW-1:0];
        else
            return v[CW-1:0];
    endfunction

    // Pipeline control.
    logic [NUM_STAGES:1] stg_valid_reg;
    logic [NUM_STAGES:1] stg_load;
    logic [NUM_STAGES:1] stg_valid_in;

    // Table addressing.
    logic [ANGLE_WIDTH-1:0]    ang       [NUM_ANG];
    logic [ROM_AW-1:0]         sin_addr  [NUM_ANG];
    logic [ROM_AW-1:0]         cos_addr  [NUM_ANG];
    logic [NUM_ANG-1:0]        sin_neg;
    logic [NUM_ANG-1:0]        cos_neg;
    logic [TRIG_MAG_WIDTH-1:0] sin_mag   [NUM_ANG];
    logic [TRIG_MAG_WIDTH-1:0] cos_mag   [NUM_ANG];

    // Stage 1: table reads under way.
    logic signed [CW-1:0]      s1_x_reg, s1_y_reg, s1_z_reg;
    logic [NUM_ANG-1:0]        s1_sin_neg_reg, s1_cos_neg_reg;
    // Stage 2: roll products.
    logic signed [PW-1:0]      s2_ycr_reg, s2_zsr_reg, s2_ysr_reg, s2_zcr_reg;
    logic signed [CW-1:0]      s2_x_reg;
    logic signed [TW-1:0]      s2_sp_reg, s2_cp_reg, s2_sy_reg, s2_cy_reg;
    // Stage 3: roll result.
    logic signed [IW-1:0]      s3_x_reg, s3_y_reg, s3_z_reg;
    logic signed [TW-1:0]      s3_sp_reg, s3_cp_reg, s3_sy_reg, s3_cy_reg;
    // Stage 4: pitch products.
    logic signed [PW-1:0]      s4_xcp_reg, s4_ysp_reg, s4_xsp_reg, s4_ycp_reg;
    logic signed [IW-1:0]      s4_z_reg;
    logic signed [TW-1:0]      s4_sy_reg, s4_cy_reg;
    // Stage 5: pitch result.
    logic signed [IW-1:0]      s5_x_reg, s5_y_reg, s5_z_reg;
    logic signed [TW-1:0]      s5_sy_reg, s5_cy_reg;
    // Stage 6: yaw products.
    logic signed [PW-1:0]      s6_xcy_reg, s6_zsy_reg, s6_zcy_reg, s6_xsy_reg;
    logic signed [IW-1:0]      s6_y_reg;
    // Stage 7: yaw result.
    logic signed [IW-1:0]      s7_x_reg, s7_y_reg, s7_z_reg;
    // Stage 8: saturated output word, already swapped.
    logic signed [CW-1:0]      s8_x_reg, s8_y_reg, s8_z_reg;

    // Trig values for roll, with the quadrant sign applied.
    logic signed [TW-1:0]      roll_sin, roll_cos;
    logic signed [IW-1:0]      s1_y_ext, s1_z_ext;

    // A stage loads when it is empty or its contents move on.
    always_comb
    begin
        stg_load[NUM_STAGES] = !stg_valid_reg[NUM_STAGES] || result.ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            stg_load[k] = !stg_valid_reg[k] || stg_load[k+1];
        end
    end

    assign stg_valid_in = {stg_valid_reg[NUM_STAGES-1:1], point.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= NUM_STAGES; k++)
            begin
                if (stg_load[k])
                    stg_valid_reg[k] <= stg_valid_in[k];
            end
        end
    end

    assign point.ready  = stg_load[1];
    assign result.valid = stg_valid_reg[NUM_STAGES];
    assign result.out_x = s8_x_reg;
    assign result.out_y = s8_y_reg;
    assign result.out_z = s8_z_reg;

    // Quadrant decode; the cosine sits one quadrant on from the sine.
    assign ang[ANG_ROLL]  = point.roll_angle;
    assign ang[ANG_PITCH] = point.pitch_angle;
    assign ang[ANG_YAW]   = point.yaw_angle;

    for (genvar g = 0; g < NUM_ANG; g++)
    begin : g_trig
        logic [1:0]     sin_quad;
        logic [1:0]     cos_quad;
        logic [STB-1:0] idx;

        assign sin_quad    = ang[g][ANGLE_WIDTH-1 -: 2];
        assign cos_quad    = sin_quad + 2'd1;
        assign idx         = quad_index(ang[g][REST_W-1:0]);
        assign sin_addr[g] = rom_addr(sin_quad, idx);
        assign cos_addr[g] = rom_addr(cos_quad, idx);
        assign sin_neg[g]  = sin_quad[1];
        assign cos_neg[g]  = cos_quad[1];

        evr_sine_rom #(
            .TABLE_BITS (SINE_TABLE_BITS)
        ) u_rom (
            .clk    (clk),
            .en     (stg_load[1]),
            .addr_a (sin_addr[g]),
            .addr_b (cos_addr[g]),
            .data_a (sin_mag[g]),
            .data_b (cos_mag[g])
        );
    end

    assign roll_sin = to_trig(sin_mag[ANG_ROLL], s1_sin_neg_reg[ANG_ROLL]);
    assign roll_cos = to_trig(cos_mag[ANG_ROLL], s1_cos_neg_reg[ANG_ROLL]);
    assign s1_y_ext = IW'(s1_y_reg);
    assign s1_z_ext = IW'(s1_z_reg);

    // Datapath registers; they carry no reset and only load with their stage.
    always_ff @(posedge clk)
    begin
        // Stage 1: capture the point alongside the table reads.
        if (stg_load[1])
        begin
            s1_x_reg       <= point.vec_x;
            s1_y_reg       <= point.vec_y;
            s1_z_reg       <= point.vec_z;
            s1_sin_neg_reg <= sin_neg;
            s1_cos_neg_reg <= cos_neg;
        end

        // Stage 2: roll about X, products.
        if (stg_load[2])
        begin
            s2_ycr_reg <= mul(s1_y_ext, roll_cos);
            s2_zsr_reg <= mul(s1_z_ext, roll_sin);
            s2_ysr_reg <= mul(s1_y_ext, roll_sin);
            s2_zcr_reg <= mul(s1_z_ext, roll_cos);
            s2_x_reg   <= s1_x_reg;
            s2_sp_reg  <= to_trig(sin_mag[ANG_PITCH], s1_sin_neg_reg[ANG_PITCH]);
            s2_cp_reg  <= to_trig(cos_mag[ANG_PITCH], s1_cos_neg_reg[ANG_PITCH]);
            s2_sy_reg  <= to_trig(sin_mag[ANG_YAW], s1_sin_neg_reg[ANG_YAW]);
            s2_cy_reg  <= to_trig(cos_mag[ANG_YAW], s1_cos_neg_reg[ANG_YAW]);
        end

        // Stage 3: roll sums, rounded.
        if (stg_load[3])
        begin
            s3_x_reg  <= IW'(s2_x_reg);
            s3_y_reg  <= rnd_diff(s2_ycr_reg, s2_zsr_reg);
            s3_z_reg  <= rnd_sum(s2_ysr_reg, s2_zcr_reg);
            s3_sp_reg <= s2_sp_reg;
            s3_cp_reg <= s2_cp_reg;
            s3_sy_reg <= s2_sy_reg;
            s3_cy_reg <= s2_cy_reg;
        end

        // Stage 4: pitch in the X-Y plane, products.
        if (stg_load[4])
        begin
            s4_xcp_reg <= mul(s3_x_reg, s3_cp_reg);
            s4_ysp_reg <= mul(s3_y_reg, s3_sp_reg);
            s4_xsp_reg <= mul(s3_x_reg, s3_sp_reg);
            s4_ycp_reg <= mul(s3_y_reg, s3_cp_reg);
            s4_z_reg   <= s3_z_reg;
            s4_sy_reg  <= s3_sy_reg;
            s4_cy_reg  <= s3_cy_reg;
        end

        // Stage 5: pitch sums, rounded.
        if (stg_load[5])
        begin
            s5_x_reg  <= rnd_diff(s4_xcp_reg, s4_ysp_reg);
            s5_y_reg  <= rnd_sum(s4_xsp_reg, s4_ycp_reg);
            s5_z_reg  <= s4_z_reg;
            s5_sy_reg <= s4_sy_reg;
            s5_cy_reg <= s4_cy_reg;
        end

        // Stage 6: yaw in the X-Z plane, products.
        if (stg_load[6])
        begin
            s6_xcy_reg <= mul(s5_x_reg, s5_cy_reg);
            s6_zsy_reg <= mul(s5_z_reg, s5_sy_reg);
            s6_zcy_reg <= mul(s5_z_reg, s5_cy_reg);
            s6_xsy_reg <= mul(s5_x_reg, s5_sy_reg);
            s6_y_reg   <= s5_y_reg;
        end

        // Stage 7: yaw sums, rounded.
        if (stg_load[7])
        begin
            s7_x_reg <= rnd_sum(s6_xcy_reg, s6_zsy_reg);
            s7_z_reg <= rnd_diff(s6_zcy_reg, s6_xsy_reg);
            s7_y_reg <= s6_y_reg;
        end

        // Stage 8: swap Y and Z and clamp to the coordinate range.
        if (stg_load[8])
        begin
            s8_x_reg <= saturate(s7_x_reg);
            s8_y_reg <= saturate(s7_z_reg);
            s8_z_reg <= saturate(s7_y_reg);
        end
    end

endmodule

`default_nettype wire
